/* rtl/recursive_mutex_table_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the recursive mutex table
// Each macro checks a property on clk, with checking held off during reset.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_MUTEX_TABLE_TOP_ASSERT_SVH
`define RECURSIVE_MUTEX_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define MTX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that an antecedent implies a consequent in the next cycle
`define MTX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MTX_ASSERT(label, prop, msg)
`define MTX_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* rtl/mtx_pkg.sv */
// ----------------------------------------------------------------------------
// mtx_pkg
// Types and constants shared by the recursive mutex table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mtx_pkg;

  // Table size and field widths
  localparam int MUTEX_ENTRIES  = 16;
  localparam int IDX_W          = 4;
  localparam int PID_W          = 4;
  localparam int CNT_W          = 8;
  // Only entries reachable by a 4-bit index are usable
  localparam int USABLE_ENTRIES = (MUTEX_ENTRIES < (1 << IDX_W)) ? MUTEX_ENTRIES
                                                                 : (1 << IDX_W);
  localparam int ENT_W          = (USABLE_ENTRIES > 1) ? $clog2(USABLE_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_LOCK   = 2'd1,
    OP_UNLOCK = 2'd2,
    OP_CLOSE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BLOCKED    = 3'd1,
    ST_RELOCK     = 3'd2,
    ST_NOT_LOCKED = 3'd3,
    ST_FULL       = 3'd4,
    ST_UNUSED     = 3'd5,
    ST_OVERFLOW   = 3'd6
  } status_t;

  typedef struct packed {
    op_t              operation;
    logic [IDX_W-1:0] mutex_index;
    logic [PID_W-1:0] requester;
    logic             recursive;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] result_index;
    logic             wake;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/mtx_if.sv */
// ----------------------------------------------------------------------------
// mtx_req_if / mtx_rsp_if
// Valid/ready channels for mutex requests and their responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtx_req_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [mtx_pkg::IDX_W-1:0] mutex_index;
  logic [mtx_pkg::PID_W-1:0] requester;
  logic                    recursive;

  modport source (output valid, operation, mutex_index, requester, recursive,
                  input ready);
  modport sink   (input valid, operation, mutex_index, requester, recursive,
                  output ready);
endinterface

interface mtx_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic [mtx_pkg::IDX_W-1:0] result_index;
  logic                      wake;

  modport source (output valid, status, result_index, wake, input ready);
  modport sink   (input valid, status, result_index, wake, output ready);
endinterface

`default_nettype wire

/* rtl/recursive_mutex_table_top.sv */
// A request passes the input register, the table decision, then the response register.
// Throughput: one request per cycle unless the response stalls; the table state
//   updates in one pass as the request moves from input register to response register.
// Backpressure holds the response register; the input register takes one more request.
// Reset (synchronous, active low) frees all entries and clears counts and holders.
// ----------------------------------------------------------------------------
// recursive_mutex_table_top
// Recursive mutex table: create, lock, unlock and close requests.
// ----------------------------------------------------------------------------
`default_nettype none

`include "recursive_mutex_table_top_assert.svh"

module recursive_mutex_table_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mtx_req_if.sink    in_req,
  mtx_rsp_if.source  out_rsp
);

  logic          s1_valid_r;
  mtx_pkg::req_t s1_req_r;
  logic          out_valid_r;
  mtx_pkg::rsp_t out_rsp_r;
  mtx_pkg::rsp_t rsp;
  logic          out_free;
  logic          fire;

  // Stage handshake
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign fire         = s1_valid_r && out_free;
  assign in_req.ready = !s1_valid_r || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
    if (in_req.ready && in_req.valid) begin
      s1_req_r.operation   <= mtx_pkg::op_t'(in_req.operation);
      s1_req_r.mutex_index <= in_req.mutex_index;
      s1_req_r.requester   <= in_req.requester;
      s1_req_r.recursive   <= in_req.recursive;
    end
  end

  mtx_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (s1_req_r),
    .rsp   (rsp)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
    if (fire) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_rsp_r.status;
  assign out_rsp.result_index = out_rsp_r.result_index;
  assign out_rsp.wake         = out_rsp_r.wake;

  `MTX_ASSERT(a_wake_ok, !(out_valid_r && out_rsp_r.wake && out_rsp_r.status != mtx_pkg::ST_OK),
    "wake with non-ok status")
  `MTX_ASSERT(a_full_idx, !(out_valid_r && out_rsp_r.status == mtx_pkg::ST_FULL &&
    out_rsp_r.result_index != '0), "full response with nonzero index")
  `MTX_ASSERT_NEXT(a_fire_out, fire, out_valid_r, "request lost between stages")

endmodule

`default_nettype wire

/* rtl/mtx_table.sv */
// ----------------------------------------------------------------------------
// mtx_table
// Mutex table state and the single-pass decision for one request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "recursive_mutex_table_top_assert.svh"

module mtx_table (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fire,
  input  wire mtx_pkg::req_t req,
  output mtx_pkg::rsp_t      rsp
);

  localparam int N = mtx_pkg::USABLE_ENTRIES;

  logic [N-1:0]                in_use_r,  in_use_nxt;
  logic [N-1:0]                rec_r,     rec_nxt;
  logic [mtx_pkg::CNT_W-1:0]   cnt_r      [N];
  logic [mtx_pkg::CNT_W-1:0]   cnt_nxt    [N];
  logic [mtx_pkg::PID_W-1:0]   holder_r   [N];
  logic [mtx_pkg::PID_W-1:0]   holder_nxt [N];

  logic                        idx_ok;
  logic [mtx_pkg::ENT_W-1:0]   ent;
  logic                        used;
  logic [mtx_pkg::CNT_W-1:0]   cnt;
  logic                        free_found;
  logic [mtx_pkg::ENT_W-1:0]   free_ent;
  logic [N-1:0]                cnt_nz;

  // Address decode of the addressed entry
  assign idx_ok = ({1'b0, req.mutex_index} < (mtx_pkg::IDX_W + 1)'(N));
  assign ent    = req.mutex_index[mtx_pkg::ENT_W-1:0];
  assign used   = idx_ok && in_use_r[ent];
  assign cnt    = cnt_r[ent];

  // Lowest free entry
  always_comb begin
    free_found = 1'b0;
    free_ent   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_ent   = mtx_pkg::ENT_W'(i);
      end
    end
  end

  // Decision and next state
  always_comb begin
    in_use_nxt = in_use_r;
    rec_nxt    = rec_r;
    cnt_nxt    = cnt_r;
    holder_nxt = holder_r;
    rsp.status       = mtx_pkg::ST_OK;
    rsp.result_index = req.mutex_index;
    rsp.wake         = 1'b0;
    if (req.operation == mtx_pkg::OP_CREATE) begin
      if (free_found) begin
        rsp.result_index     = mtx_pkg::IDX_W'(free_ent);
        in_use_nxt[free_ent] = 1'b1;
        rec_nxt[free_ent]    = req.recursive;
        cnt_nxt[free_ent]    = '0;
        holder_nxt[free_ent] = '0;
      end else begin
        rsp.status       = mtx_pkg::ST_FULL;
        rsp.result_index = '0;
      end
    end else if (!used) begin
      rsp.status = mtx_pkg::ST_UNUSED;
    end else begin
      unique case (req.operation)
        mtx_pkg::OP_LOCK: begin
          if (cnt == '0) begin
            cnt_nxt[ent]    = mtx_pkg::CNT_W'(1);
            holder_nxt[ent] = req.requester;
          end else if (holder_r[ent] != req.requester) begin
            rsp.status = mtx_pkg::ST_BLOCKED;
          end else if (!rec_r[ent]) begin
            rsp.status = mtx_pkg::ST_RELOCK;
          end else if (cnt == mtx_pkg::COUNT_MAX) begin
            rsp.status = mtx_pkg::ST_OVERFLOW;
          end else begin
            cnt_nxt[ent] = cnt + mtx_pkg::CNT_W'(1);
          end
        end
        mtx_pkg::OP_UNLOCK: begin
          if (cnt == '0) begin
            rsp.status = mtx_pkg::ST_NOT_LOCKED;
          end else if (rec_r[ent] && cnt != mtx_pkg::CNT_W'(1)) begin
            cnt_nxt[ent] = cnt - mtx_pkg::CNT_W'(1);
          end else begin
            // last release frees the mutex
            cnt_nxt[ent]    = '0;
            holder_nxt[ent] = '0;
            rsp.wake        = 1'b1;
          end
        end
        default: begin
          // close: free the entry even if locked
          in_use_nxt[ent] = 1'b0;
          rec_nxt[ent]    = 1'b0;
          cnt_nxt[ent]    = '0;
          holder_nxt[ent] = '0;
          rsp.wake        = 1'b1;
        end
      endcase
    end
  end

  // Table state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      rec_r    <= '0;
      for (int i = 0; i < N; i++) begin
        cnt_r[i]    <= '0;
        holder_r[i] <= '0;
      end
    end else if (fire) begin
      in_use_r <= in_use_nxt;
      rec_r    <= rec_nxt;
      cnt_r    <= cnt_nxt;
      holder_r <= holder_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      cnt_nz[i] = (cnt_r[i] != '0);
    end
  end

  `MTX_ASSERT(a_cnt_in_use, !(|(cnt_nz & ~in_use_r)), "lock count on free entry")
  `MTX_ASSERT(a_rec_in_use, !(|(rec_r & ~in_use_r)), "recursive bit on free entry")
  `MTX_ASSERT_NEXT(a_create_alloc,
    fire && req.operation == mtx_pkg::OP_CREATE && rsp.status == mtx_pkg::ST_OK,
    in_use_r[$past(free_ent)], "created entry not marked in use")
  `MTX_ASSERT_NEXT(a_close_frees, fire && req.operation == mtx_pkg::OP_CLOSE && used,
    !in_use_r[$past(ent)], "closed entry still in use")

endmodule

`default_nettype wire
